/* hw/rtl/tmhq_pkg.sv */
// timer min-heap queue: shared types, codes and the wrap-aware time compare
// no dependencies
package tmhq_pkg;

	localparam int TIME_BITS = 32;

	typedef logic [TIME_BITS-1:0] tm_t;

	localparam logic [2:0] FUNC_ADD    = 3'd0;
	localparam logic [2:0] FUNC_FIRE   = 3'd1;
	localparam logic [2:0] FUNC_ADJUST = 3'd2;
	localparam logic [2:0] FUNC_SWEEP  = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_SUM   = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_ABSENT = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_FIRE,
		OP_ADJUST,
		OP_SWEEP,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       in_range;
		logic [7:0] id;
		tm_t        expiry;
		tm_t        now;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         id;
		logic [1:0]         status;
		logic signed [31:0] delay;
		logic               last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_LRD,
		S_LLD,
		S_DRD,
		S_DCMP,
		S_URD,
		S_UCMP,
		S_FIN,
		S_SWP,
		S_SWC,
		S_EMIT
	} state_t;

	function automatic logic earlier(tm_t a, tm_t b);
		tm_t d;
		d = a - b;
		return d[TIME_BITS-1];
	endfunction

endpackage

/* hw/rtl/tmhq_chan_if.sv */
// timer min-heap queue: valid/ready channel interfaces for request and result items
// no dependencies
interface tmhq_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [7:0]  timer_id;
	logic [30:0] timeout_ms;
	logic [31:0] now_ms;

	modport source(output valid, func, timer_id, timeout_ms, now_ms, input ready);
	modport sink(input valid, func, timer_id, timeout_ms, now_ms, output ready);
endinterface

interface tmhq_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [7:0]         fired_id;
	logic [1:0]         status;
	logic signed [31:0] next_delay;
	logic               last;

	modport source(output valid, kind, fired_id, status, next_delay, last, input ready);
	modport sink(input valid, kind, fired_id, status, next_delay, last, output ready);
endinterface

/* hw/rtl/tmhq_front.sv */
// timer min-heap queue front: takes request items, decodes the operation,
// computes the expiry and the id range check; depends on tmhq_pkg, tmhq_in_if
module tmhq_front #(
	parameter int ID_COUNT = 256
) (
	tmhq_in_if.sink         req,
	output logic            push_valid,
	input  logic            push_ready,
	output tmhq_pkg::cmd_t  push_data
);
	import tmhq_pkg::*;

	op_t op;

	always_comb begin
		unique case (req.func)
			FUNC_ADD:    op = OP_ADD;
			FUNC_FIRE:   op = OP_FIRE;
			FUNC_ADJUST: op = OP_ADJUST;
			FUNC_SWEEP:  op = OP_SWEEP;
			FUNC_CLEAR:  op = OP_CLEAR;
			default:     op = OP_NOP;
		endcase
	end

	assign push_valid         = req.valid;
	assign req.ready          = push_ready;
	assign push_data.op       = op;
	assign push_data.in_range = (32'(req.timer_id) < 32'(ID_COUNT));
	assign push_data.id       = req.timer_id;
	assign push_data.expiry   = req.now_ms + {1'b0, req.timeout_ms};
	assign push_data.now      = req.now_ms;

endmodule

/* hw/rtl/tmhq_fifo.sv */
// timer min-heap queue: two-entry command queue between front and back
// depends on tmhq_pkg
module tmhq_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tmhq_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tmhq_pkg::cmd_t pop_data
);
	import tmhq_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

/* hw/rtl/tmhq_back.sv */
// timer min-heap queue back: heap memory, id-to-slot table, sift sequencer
// and result register; depends on tmhq_pkg, tmhq_out_if
module tmhq_back #(
	parameter int CAPACITY = 32,
	parameter int ID_COUNT = 256,
	localparam int W  = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  tmhq_pkg::cmd_t pop_data,
	tmhq_out_if.source     rsp,
	output logic [CW-1:0]  heap_count
);
	import tmhq_pkg::*;

	localparam int ID_DEPTH = (ID_COUNT < 256) ? ID_COUNT : 256;
	localparam int IDW      = $clog2(ID_DEPTH);
	localparam int CIW      = $clog2(2 * CAPACITY + 1);

	typedef struct packed {
		tm_t            exp;
		logic [IDW-1:0] id;
	} ent_t;

	ent_t           heap_mem [CAPACITY];
	logic [W-1:0]   slot_mem [ID_DEPTH];

	state_t         state_q, state_d, ret_q, ret_d;
	cmd_t           cmd_q, cmd_d;
	ent_t           node_q, node_d;
	logic [W-1:0]   hole_q, hole_d;
	logic           moved_q, moved_d;
	logic           down_only_q, down_only_d;
	logic           sweep_q, sweep_d;
	logic [CW-1:0]  count_q, count_d;
	logic [ID_DEPTH-1:0] valid_q, valid_d;
	rsp_t           res_q, res_d;
	rsp_t           out_q, out_d;
	logic           out_valid_q, out_valid_d;

	ent_t           rd_a_q, rd_b_q;
	logic [W-1:0]   slot_rd_q;
	logic [W-1:0]   addr_a, addr_b;
	logic           hw_en;
	logic [W-1:0]   hw_addr;
	ent_t           hw_data;
	logic           sw_en;
	logic [IDW-1:0] sw_addr;
	logic [W-1:0]   sw_data;

	logic [CIW-1:0] l_idx, r_idx, c_idx;
	logic           l_ok, r_ok, use_r;
	logic [W-1:0]   p_idx;
	logic [CW-1:0]  cnt_m1;
	logic           present;
	ent_t           child;
	tm_t            gap;
	logic [IDW-1:0] cmd_idx;

	assign l_idx   = CIW'({hole_q, 1'b1});
	assign r_idx   = l_idx + 1'b1;
	assign l_ok    = l_idx < CIW'(count_q);
	assign r_ok    = r_idx < CIW'(count_q);
	assign use_r   = r_ok && earlier(rd_b_q.exp, rd_a_q.exp);
	assign child   = use_r ? rd_b_q : rd_a_q;
	assign c_idx   = use_r ? r_idx : l_idx;
	assign p_idx   = (hole_q - 1'b1) >> 1;
	assign cnt_m1  = count_q - 1'b1;
	assign cmd_idx = cmd_q.id[IDW-1:0];
	assign present = cmd_q.in_range && valid_q[cmd_idx];
	assign gap     = rd_a_q.exp - cmd_q.now;

	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		cmd_d       = cmd_q;
		node_d      = node_q;
		hole_d      = hole_q;
		moved_d     = moved_q;
		down_only_d = down_only_q;
		sweep_d     = sweep_q;
		count_d     = count_q;
		valid_d     = valid_q;
		res_d       = res_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !rsp.ready;
		pop_ready   = 1'b0;
		addr_a      = '0;
		addr_b      = '0;
		hw_en       = 1'b0;
		hw_addr     = hole_q;
		hw_data     = node_q;
		sw_en       = 1'b0;
		sw_addr     = node_q.id;
		sw_data     = hole_q;

		unique case (state_q)
			S_IDLE: begin
				if (pop_valid) begin
					pop_ready = 1'b1;
					cmd_d     = pop_data;
					sweep_d   = 1'b0;
					moved_d   = 1'b0;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				res_d  = '{kind: KIND_ACK, id: cmd_q.id, status: STAT_OK, delay: '0,
					last: 1'b1};
				ret_d   = S_IDLE;
				state_d = S_EMIT;
				node_d  = '{exp: cmd_q.expiry, id: cmd_idx};
				hole_d  = slot_rd_q;
				unique case (cmd_q.op)
					OP_ADD: begin
						if (!cmd_q.in_range) begin
							res_d.status = STAT_ABSENT;
						end else if (present) begin
							down_only_d = 1'b0;
							state_d     = S_DRD;
						end else if (count_q == CW'(CAPACITY)) begin
							res_d.status = STAT_FULL;
						end else begin
							hole_d           = count_q[W-1:0];
							count_d          = count_q + 1'b1;
							valid_d[cmd_idx] = 1'b1;
							state_d          = S_URD;
						end
					end
					OP_FIRE: begin
						if (!present) begin
							res_d.status = STAT_ABSENT;
						end else begin
							res_d.kind       = KIND_FIRED;
							valid_d[cmd_idx] = 1'b0;
							count_d          = cnt_m1;
							if (CW'(slot_rd_q) != cnt_m1) state_d = S_LRD;
						end
					end
					OP_ADJUST: begin
						if (!present) begin
							res_d.status = STAT_ABSENT;
						end else begin
							down_only_d = 1'b1;
							state_d     = S_DRD;
						end
					end
					OP_SWEEP: begin
						sweep_d = 1'b1;
						state_d = S_SWP;
					end
					OP_CLEAR: begin
						count_d = '0;
						valid_d = '0;
					end
					OP_NOP: begin
					end
					default: begin
					end
				endcase
			end
			S_LRD: begin
				addr_a  = count_q[W-1:0];
				state_d = S_LLD;
			end
			S_LLD: begin
				node_d      = rd_a_q;
				down_only_d = 1'b0;
				state_d     = S_DRD;
			end
			S_DRD: begin
				if (l_ok) begin
					addr_a  = l_idx[W-1:0];
					addr_b  = r_ok ? r_idx[W-1:0] : l_idx[W-1:0];
					state_d = S_DCMP;
				end else begin
					state_d = (moved_q || down_only_q) ? S_FIN : S_URD;
				end
			end
			S_DCMP: begin
				if (earlier(node_q.exp, child.exp)) begin
					state_d = (moved_q || down_only_q) ? S_FIN : S_URD;
				end else begin
					hw_en   = 1'b1;
					hw_data = child;
					sw_en   = 1'b1;
					sw_addr = child.id;
					hole_d  = c_idx[W-1:0];
					moved_d = 1'b1;
					state_d = S_DRD;
				end
			end
			S_URD: begin
				if (hole_q == '0) begin
					state_d = S_FIN;
				end else begin
					addr_a  = p_idx;
					state_d = S_UCMP;
				end
			end
			S_UCMP: begin
				if (earlier(rd_a_q.exp, node_q.exp)) begin
					state_d = S_FIN;
				end else begin
					hw_en   = 1'b1;
					hw_data = rd_a_q;
					sw_en   = 1'b1;
					sw_addr = rd_a_q.id;
					hole_d  = p_idx;
					state_d = S_URD;
				end
			end
			S_FIN: begin
				hw_en   = 1'b1;
				sw_en   = 1'b1;
				state_d = sweep_q ? S_SWP : S_EMIT;
			end
			S_SWP: begin
				moved_d = 1'b0;
				if (count_q == '0) begin
					res_d = '{kind: KIND_SUM, id: 8'd0, status: STAT_OK, delay: '1,
						last: 1'b1};
					ret_d   = S_IDLE;
					state_d = S_EMIT;
				end else begin
					addr_a  = '0;
					state_d = S_SWC;
				end
			end
			S_SWC: begin
				state_d = S_EMIT;
				if (gap == '0 || gap[TIME_BITS-1]) begin
					res_d = '{kind: KIND_FIRED, id: 8'(rd_a_q.id), status: STAT_OK,
						delay: '0, last: 1'b0};
					valid_d[rd_a_q.id] = 1'b0;
					count_d = cnt_m1;
					hole_d  = '0;
					ret_d   = (cnt_m1 == '0) ? S_SWP : S_LRD;
				end else begin
					res_d = '{kind: KIND_SUM, id: 8'd0, status: STAT_OK,
						delay: {1'b0, gap[TIME_BITS-2:0]}, last: 1'b1};
					ret_d = S_IDLE;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					out_d       = res_q;
					out_valid_d = 1'b1;
					state_d     = ret_q;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			count_q     <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			count_q     <= count_d;
			valid_q     <= valid_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		node_q      <= node_d;
		hole_q      <= hole_d;
		moved_q     <= moved_d;
		down_only_q <= down_only_d;
		sweep_q     <= sweep_d;
		res_q       <= res_d;
		out_q       <= out_d;
	end

	always_ff @(posedge clk) begin
		if (hw_en) heap_mem[hw_addr] <= hw_data;
		rd_a_q <= heap_mem[addr_a];
		rd_b_q <= heap_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (sw_en) slot_mem[sw_addr] <= sw_data;
		slot_rd_q <= slot_mem[pop_data.id[IDW-1:0]];
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = out_q.kind;
	assign rsp.fired_id   = out_q.id;
	assign rsp.status     = out_q.status;
	assign rsp.next_delay = out_q.delay;
	assign rsp.last       = out_q.last;
	assign heap_count     = count_q;

endmodule

/* hw/rtl/timer_min_heap_queue_unit.sv */
// timer min-heap queue top level: front decoder, command queue and heap back end
// depends on tmhq_pkg, tmhq_chan_if, tmhq_front, tmhq_fifo, tmhq_back
//
// req carries one operation per item: add/re-arm, fire by id, adjust, sweep, clear.
// rsp carries result items; the final result of each request has last set.
// A sweep gives one fired item per expired timer, earliest first, then a summary
// with the delay to the next expiry (-1 when the heap is empty).
// The command queue holds up to two requests ahead while the back works on one.
// An acknowledge without heap movement, with the back end idle, passes the
// command queue entry, the command register, the result register and the output
// register in turn; each heap level of a sift takes one registered read of
// parent or both children, then a compare and move. Each swept timer costs
// about as much as a fire. The heap memory port (read, then write of one moved
// entry) sets the cost of each level.
// Reset empties the heap and marks every id absent at once; no clearing pass.
// When rsp stalls, one result waits in the output register and the back end
// holds its next result until that one is taken; requests queue until full.
module timer_min_heap_queue_unit #(
	parameter int CAPACITY = 32,
	parameter int ID_COUNT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	tmhq_in_if.sink    req,
	tmhq_out_if.source rsp
);
	import tmhq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic          push_valid, push_ready;
	cmd_t          push_data;
	logic          pop_valid, pop_ready;
	cmd_t          pop_data;
	logic [CW-1:0] heap_count;

	tmhq_front #(.ID_COUNT(ID_COUNT)) u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tmhq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tmhq_back #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.rsp        (rsp),
		.heap_count (heap_count)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		heap_count <= CW'(CAPACITY))
		else $error("heap count above capacity");

	a_summary_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_SUM |->
		rsp.last && rsp.fired_id == 8'd0 && rsp.status == STAT_OK)
		else $error("malformed sweep summary");

	a_ack_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_ACK |-> rsp.last && rsp.next_delay == 32'sd0)
		else $error("malformed acknowledge");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_FIRED |-> rsp.status == STAT_OK)
		else $error("fired item with bad status");

endmodule
